FILE: rtl/core/max_components_after_vertex_removal_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex removal block
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MAX_COMPONENTS_AFTER_VERTEX_REMOVAL_MACROS_SVH
`define MAX_COMPONENTS_AFTER_VERTEX_REMOVAL_MACROS_SVH
`ifndef SYNTHESIS
// hold: cond must be true at every edge outside reset
`define MCAVR_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("check failed");
// trigger at one edge implies result at the next
`define MCAVR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("check failed");
`else
`define MCAVR_ASSERT(lbl, cond)
`define MCAVR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/core/mcavr_pkg.sv
// ----------------------------------------------------------------------------
// mcavr_pkg
// Sizes, widths and sequencer states of the vertex removal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mcavr_pkg;
	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 4096;
	localparam int VTX_W        = 10;              // vertex index
	localparam int CNT_W        = 11;              // counts up to MAX_VERTICES
	localparam int EADDR_W      = 13;              // adjacency entry address
	localparam int EHEAD_W      = 14;              // entry address plus one
	localparam int ETOT_W       = 13;              // stored edge count
	localparam int FRAME_W      = VTX_W + EHEAD_W; // walk frame

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_E_A,
		S_E_RB,
		S_E_B,
		S_W_ROOT,
		S_W_CHK,
		S_W_RPUSH,
		S_W_TOP,
		S_W_EDGE,
		S_W_NB,
		S_W_PUSH,
		S_W_BACK,
		S_W_POP,
		S_W_POP2,
		S_W_PAR,
		S_W_PAR2
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/core/max_components_after_vertex_removal.sv
// ----------------------------------------------------------------------------
// max_components_after_vertex_removal
// Loads an undirected graph and reports the most components one vertex
// removal can leave.
// ----------------------------------------------------------------------------
// Words with kind 0 add an edge. A stored edge passes through S_E_A, S_E_RB
// and S_E_B, bound by the single read port of the list head RAM; a dropped
// edge does not stall the input. Edges with an endpoint at or above the
// vertex count, or beyond 4096 stored edges, are dropped and flagged. A word
// with kind 1 runs a depth-first walk in one sequencer that drives all stores
// through one port each. It steps through S_W_ROOT and S_W_CHK per vertex,
// S_W_TOP and S_W_EDGE per list entry (two entries per edge), S_W_POP and
// S_W_POP2 per pop, and S_W_PAR and S_W_PAR2 for a pop below the root.
// One result word follows; then a clearing pass wipes the list heads,
// discovery numbers and piece counts. The same pass runs after reset.
// in_stall stays high throughout the walk and the pass.
`timescale 1ns / 1ps
`default_nettype none
`include "max_components_after_vertex_removal_macros.svh"
module max_components_after_vertex_removal
	import mcavr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             kind,
	input  wire logic [VTX_W-1:0] endpoint_a,
	input  wire logic [VTX_W-1:0] endpoint_b,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [CNT_W-1:0] max_components,
	output logic                  edge_dropped
);
	localparam logic [CNT_W-1:0]   NV_MAX   = CNT_W'(MAX_VERTICES);
	localparam logic [EHEAD_W-1:0] HEAD_MAX = EHEAD_W'(2 * MAX_EDGES);

	state_t state_q, state_d;

	// configuration and loader
	logic [CNT_W-1:0]  vcount_q;
	logic [CNT_W-1:0]  nv;
	logic [ETOT_W-1:0] etot_q;
	logic              drop_q;
	logic [VTX_W-1:0]  a_q, b_q;
	logic [CNT_W-1:0]  clr_q;

	// walk registers
	logic [CNT_W-1:0]   r_q, counter_q, comps_q, best_q, cbest_q, sp_q;
	logic [VTX_W-1:0]   u_q, w_q;
	logic [EHEAD_W-1:0] e_q;
	logic [CNT_W-1:0]   d_q, lowu_q;

	// RAM ports
	logic               tgt_we, lnk_we, vfe_we, disc_we, low_we, pc_we, stk_we;
	logic [EADDR_W-1:0] ent_waddr, ent_raddr;
	logic [VTX_W-1:0]   tgt_wdata, tgt_rdata;
	logic [EHEAD_W-1:0] lnk_wdata, lnk_rdata, vfe_wdata, vfe_rdata;
	logic [VTX_W-1:0]   vfe_waddr, vfe_raddr, disc_waddr, disc_raddr;
	logic [VTX_W-1:0]   low_waddr, low_raddr, pc_waddr, pc_raddr, stk_waddr, stk_raddr;
	logic [CNT_W-1:0]   disc_wdata, disc_rdata, low_wdata, low_rdata;
	logic [CNT_W-1:0]   pc_wdata, pc_rdata;
	logic [FRAME_W-1:0] stk_wdata, stk_rdata;

	logic               acc, bad_edge, walk_done, out_free;
	logic [EHEAD_W-1:0] head_a, head_b;
	logic [CNT_W-1:0]   cbest_new, best_new, answer, sp_m1, sp_m2;
	logic [VTX_W-1:0]   par_v;

	assign nv        = (vcount_q > NV_MAX) ? NV_MAX : vcount_q;
	assign in_stall  = (state_q != S_IDLE);
	assign acc       = in_valid && !in_stall;
	assign bad_edge  = ({1'b0, endpoint_a} >= nv) || ({1'b0, endpoint_b} >= nv)
		|| (etot_q >= ETOT_W'(MAX_EDGES));
	// entry pair for the next edge: heads hold address plus one
	assign head_a    = {1'b0, etot_q[ETOT_W-2:0], 1'b0} + EHEAD_W'(1);
	assign head_b    = {1'b0, etot_q[ETOT_W-2:0], 1'b1} + EHEAD_W'(1);
	assign walk_done = (r_q == nv);
	assign out_free  = !(out_valid && out_stall);
	assign cbest_new = (pc_rdata > cbest_q) ? pc_rdata : cbest_q;
	assign best_new  = (cbest_new > best_q) ? cbest_new : best_q;
	assign answer    = (comps_q != '0) ? best_q + comps_q - CNT_W'(1) : '0;
	assign sp_m1     = sp_q - CNT_W'(1);
	assign sp_m2     = sp_q - CNT_W'(2);
	assign par_v     = stk_rdata[FRAME_W-1:EHEAD_W];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:   if (clr_q == NV_MAX - CNT_W'(1)) state_d = S_IDLE;
			S_IDLE: begin
				if (acc && kind) begin
					state_d = S_W_ROOT;
				end else if (acc && !bad_edge) begin
					state_d = S_E_A;
				end
			end
			S_E_A:     state_d = S_E_RB;
			S_E_RB:    state_d = S_E_B;
			S_E_B:     state_d = S_IDLE;
			S_W_ROOT: begin
				if (!walk_done) begin
					state_d = S_W_CHK;
				end else if (out_free) begin
					state_d = S_CLEAR;
				end
			end
			S_W_CHK:   state_d = (disc_rdata != '0) ? S_W_ROOT : S_W_RPUSH;
			S_W_RPUSH: state_d = S_W_TOP;
			S_W_TOP:   state_d = (e_q != '0 && e_q <= HEAD_MAX) ? S_W_EDGE : S_W_POP;
			S_W_EDGE:  state_d = ({1'b0, tgt_rdata} >= nv) ? S_W_TOP : S_W_NB;
			S_W_NB: begin
				if (disc_rdata != '0) begin
					state_d = S_W_BACK;
				end else if (sp_q == NV_MAX) begin
					state_d = S_W_TOP;
				end else begin
					state_d = S_W_PUSH;
				end
			end
			S_W_PUSH:  state_d = S_W_TOP;
			S_W_BACK:  state_d = S_W_TOP;
			S_W_POP:   state_d = S_W_POP2;
			S_W_POP2:  state_d = (sp_q == CNT_W'(1)) ? S_W_ROOT : S_W_PAR;
			S_W_PAR:   state_d = S_W_PAR2;
			S_W_PAR2:  state_d = S_W_TOP;
			default:   state_d = S_CLEAR;
		endcase
	end

	// RAM controls
	always_comb begin
		tgt_we = 1'b0; lnk_we = 1'b0; vfe_we = 1'b0; disc_we = 1'b0;
		low_we = 1'b0; pc_we = 1'b0; stk_we = 1'b0;
		ent_waddr = '0; ent_raddr = e_q[EADDR_W-1:0] - EADDR_W'(1);
		tgt_wdata = '0; lnk_wdata = '0;
		vfe_waddr = '0; vfe_wdata = '0; vfe_raddr = '0;
		disc_waddr = '0; disc_wdata = '0; disc_raddr = '0;
		low_waddr = '0; low_wdata = '0; low_raddr = u_q;
		pc_waddr = '0; pc_wdata = '0; pc_raddr = u_q;
		stk_waddr = sp_m1[VTX_W-1:0]; stk_wdata = {u_q, e_q};
		stk_raddr = sp_m2[VTX_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				vfe_we = 1'b1; disc_we = 1'b1; pc_we = 1'b1;
				vfe_waddr = clr_q[VTX_W-1:0];
				disc_waddr = clr_q[VTX_W-1:0];
				pc_waddr = clr_q[VTX_W-1:0];
			end
			S_IDLE:  vfe_raddr = endpoint_a;
			S_E_A: begin
				tgt_we = 1'b1; lnk_we = 1'b1; vfe_we = 1'b1;
				ent_waddr = {etot_q[ETOT_W-2:0], 1'b0};
				tgt_wdata = b_q; lnk_wdata = vfe_rdata;
				vfe_waddr = a_q; vfe_wdata = head_a;
			end
			S_E_RB:  vfe_raddr = b_q;
			S_E_B: begin
				tgt_we = 1'b1; lnk_we = 1'b1; vfe_we = 1'b1;
				ent_waddr = {etot_q[ETOT_W-2:0], 1'b1};
				tgt_wdata = a_q; lnk_wdata = vfe_rdata;
				vfe_waddr = b_q; vfe_wdata = head_b;
			end
			S_W_ROOT: disc_raddr = r_q[VTX_W-1:0];
			S_W_CHK: begin
				vfe_raddr = r_q[VTX_W-1:0];
				if (disc_rdata == '0) begin
					disc_we = 1'b1; low_we = 1'b1; pc_we = 1'b1;
					disc_waddr = r_q[VTX_W-1:0]; disc_wdata = counter_q + CNT_W'(1);
					low_waddr = r_q[VTX_W-1:0]; low_wdata = counter_q + CNT_W'(1);
					pc_waddr = r_q[VTX_W-1:0];
				end
			end
			S_W_EDGE: disc_raddr = tgt_rdata;
			S_W_NB: begin
				vfe_raddr = w_q;
				if (disc_rdata == '0 && sp_q != NV_MAX) begin
					disc_we = 1'b1; low_we = 1'b1; pc_we = 1'b1; stk_we = 1'b1;
					disc_waddr = w_q; disc_wdata = counter_q + CNT_W'(1);
					low_waddr = w_q; low_wdata = counter_q + CNT_W'(1);
					pc_waddr = w_q; pc_wdata = CNT_W'(1);
				end
			end
			S_W_BACK: begin
				if (d_q < low_rdata) begin
					low_we = 1'b1; low_waddr = u_q; low_wdata = d_q;
				end
			end
			S_W_PAR: begin
				low_raddr = par_v; disc_raddr = par_v; pc_raddr = par_v;
			end
			S_W_PAR2: begin
				if (lowu_q < low_rdata) begin
					low_we = 1'b1; low_waddr = u_q; low_wdata = lowu_q;
				end
				if (lowu_q >= disc_rdata) begin
					pc_we = 1'b1; pc_waddr = u_q; pc_wdata = pc_rdata + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// control and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			vcount_q <= '0; etot_q <= '0; drop_q <= 1'b0; clr_q <= '0;
			out_valid <= 1'b0;
			r_q <= '0; counter_q <= '0; comps_q <= '0; best_q <= '0;
			cbest_q <= '0; sp_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: clr_q <= clr_q + CNT_W'(1);
				S_IDLE: begin
					clr_q <= '0;
					if (acc && kind) begin
						r_q <= '0; counter_q <= '0; comps_q <= '0; best_q <= '0;
					end else if (acc && bad_edge) begin
						drop_q <= 1'b1;
					end
				end
				S_E_B: etot_q <= etot_q + ETOT_W'(1);
				S_W_ROOT: begin
					if (walk_done && out_free) begin
						out_valid <= 1'b1;
						etot_q <= '0;
						drop_q <= 1'b0;
					end
				end
				S_W_CHK: begin
					if (disc_rdata != '0) begin
						r_q <= r_q + CNT_W'(1);
					end else begin
						comps_q <= comps_q + CNT_W'(1);
						counter_q <= counter_q + CNT_W'(1);
						cbest_q <= '0;
					end
				end
				S_W_RPUSH: sp_q <= CNT_W'(1);
				S_W_NB: begin
					if (disc_rdata == '0 && sp_q != NV_MAX) begin
						counter_q <= counter_q + CNT_W'(1);
					end
				end
				S_W_PUSH: sp_q <= sp_q + CNT_W'(1);
				S_W_POP2: begin
					cbest_q <= cbest_new;
					sp_q <= sp_m1;
					if (sp_q == CNT_W'(1)) begin
						best_q <= best_new;
						r_q <= r_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				a_q <= endpoint_a;
				b_q <= endpoint_b;
			end
			S_W_ROOT: begin
				if (walk_done && out_free) begin
					max_components <= answer;
					edge_dropped <= drop_q;
				end
			end
			S_W_RPUSH: begin
				u_q <= r_q[VTX_W-1:0];
				e_q <= vfe_rdata;
			end
			S_W_EDGE: begin
				w_q <= tgt_rdata;
				e_q <= lnk_rdata;
			end
			S_W_NB:   d_q <= disc_rdata;
			S_W_PUSH: begin
				u_q <= w_q;
				e_q <= vfe_rdata;
			end
			S_W_POP2: lowu_q <= low_rdata;
			S_W_PAR: begin
				u_q <= par_v;
				e_q <= stk_rdata[EHEAD_W-1:0];
			end
			default: ;
		endcase
	end

	mcavr_ram #(.DEPTH(2 * MAX_EDGES), .WIDTH(VTX_W)) u_tgt (
		.clk(clk), .we(tgt_we), .waddr(ent_waddr), .wdata(tgt_wdata),
		.raddr(ent_raddr), .rdata(tgt_rdata));
	mcavr_ram #(.DEPTH(2 * MAX_EDGES), .WIDTH(EHEAD_W)) u_lnk (
		.clk(clk), .we(lnk_we), .waddr(ent_waddr), .wdata(lnk_wdata),
		.raddr(ent_raddr), .rdata(lnk_rdata));
	mcavr_ram #(.DEPTH(MAX_VERTICES), .WIDTH(EHEAD_W)) u_vfe (
		.clk(clk), .we(vfe_we), .waddr(vfe_waddr), .wdata(vfe_wdata),
		.raddr(vfe_raddr), .rdata(vfe_rdata));
	mcavr_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CNT_W)) u_disc (
		.clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
		.raddr(disc_raddr), .rdata(disc_rdata));
	mcavr_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CNT_W)) u_low (
		.clk(clk), .we(low_we), .waddr(low_waddr), .wdata(low_wdata),
		.raddr(low_raddr), .rdata(low_rdata));
	mcavr_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CNT_W)) u_pc (
		.clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
		.raddr(pc_raddr), .rdata(pc_rdata));
	mcavr_ram #(.DEPTH(MAX_VERTICES), .WIDTH(FRAME_W)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata));

	`MCAVR_ASSERT(a_sp_bound, sp_q <= NV_MAX)
	`MCAVR_ASSERT(a_etot_bound, etot_q <= ETOT_W'(MAX_EDGES))
	`MCAVR_ASSERT(a_counter_bound, counter_q <= NV_MAX)
	`MCAVR_ASSERT_NEXT(a_finish_walk, in_valid && !in_stall && kind, state_q == S_W_ROOT)
endmodule
`default_nettype wire

FILE: rtl/core/mcavr_ram.sv
// ----------------------------------------------------------------------------
// mcavr_ram
// Single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mcavr_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: bench/tb_max_components_after_vertex_removal.sv
// ----------------------------------------------------------------------------
// Testbench for max_components_after_vertex_removal
// Loads many small graphs, plus a few at full size. A scoreboard re-computes
// the answer for every finish word and checks each result word against it
// while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_max_components_after_vertex_removal;
	import mcavr_pkg::*;

	typedef struct {
		logic [CNT_W-1:0] max_components;
		logic             edge_dropped;
	} answer_t;

	// Scoreboard: keeps its own copy of the graph and computes each answer
	class answer_board;
		int unsigned vcount;
		int unsigned etarget [2*MAX_EDGES];
		int unsigned elink   [2*MAX_EDGES];
		int unsigned head    [MAX_VERTICES];
		int unsigned disc    [MAX_VERTICES];
		int unsigned lowv    [MAX_VERTICES];
		int unsigned pieces  [MAX_VERTICES];
		int unsigned stk_v   [MAX_VERTICES];
		int unsigned stk_e   [MAX_VERTICES];
		int unsigned stored;
		bit          dropped;
		answer_t     waiting[$];
		int          fails;
		int          checked;

		function new();
			vcount  = 0;
			fails   = 0;
			checked = 0;
			foreach (etarget[i]) begin
				etarget[i] = 0;
				elink[i]   = 0;
			end
			foreach (lowv[i]) begin
				lowv[i]  = 0;
				stk_v[i] = 0;
				stk_e[i] = 0;
			end
			wipe();
		endfunction

		function void wipe();
			foreach (head[i]) begin
				head[i]   = 0;
				disc[i]   = 0;
				pieces[i] = 0;
			end
			stored  = 0;
			dropped = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			vcount = v;
		endfunction

		function int unsigned live_count();
			return (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
		endfunction

		function void store_edge(int unsigned a, int unsigned b);
			int unsigned nv;
			int unsigned i;
			nv = live_count();
			if (a >= nv || b >= nv || stored >= MAX_EDGES) begin
				dropped = 1;
				return;
			end
			i = 2 * stored;
			etarget[i]   = b;
			elink[i]     = head[a];
			head[a]      = i + 1;
			etarget[i+1] = a;
			elink[i+1]   = head[b];
			head[b]      = i + 2;
			stored++;
		endfunction

		function int unsigned most_pieces();
			int unsigned nv, counter, comps, best_all, sp, comp_best;
			int unsigned u, e, w, p;
			nv       = live_count();
			counter  = 0;
			comps    = 0;
			best_all = 0;
			for (int unsigned r = 0; r < nv; r++) begin
				if (disc[r] != 0)
					continue;
				comps++;
				counter++;
				comp_best = 0;
				disc[r]   = counter;
				lowv[r]   = counter;
				pieces[r] = 0;
				stk_v[0]  = r;
				stk_e[0]  = head[r];
				sp = 1;
				while (sp > 0) begin
					u = stk_v[sp-1];
					e = stk_e[sp-1];
					if (e != 0 && e <= 2 * MAX_EDGES) begin
						w = etarget[e-1];
						stk_e[sp-1] = elink[e-1];
						if (w >= nv)
							continue;
						if (disc[w] == 0) begin
							if (sp >= MAX_VERTICES)
								continue;
							counter++;
							disc[w]   = counter;
							lowv[w]   = counter;
							pieces[w] = 1;
							stk_v[sp] = w;
							stk_e[sp] = head[w];
							sp++;
						end else if (disc[w] < lowv[u]) begin
							lowv[u] = disc[w];
						end
					end else begin
						sp--;
						if (pieces[u] > comp_best)
							comp_best = pieces[u];
						if (sp > 0) begin
							p = stk_v[sp-1];
							if (lowv[u] < lowv[p])
								lowv[p] = lowv[u];
							if (lowv[u] >= disc[p])
								pieces[p]++;
						end
					end
				end
				if (comp_best > best_all)
					best_all = comp_best;
			end
			return comps ? best_all + comps - 1 : 0;
		endfunction

		function void note_word(logic k, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
			answer_t ans;
			if (!k) begin
				store_edge(a, b);
			end else begin
				ans.max_components = CNT_W'(most_pieces());
				ans.edge_dropped   = dropped;
				waiting = {waiting, ans};
				wipe();
			end
		endfunction

		function void check_word(logic [CNT_W-1:0] mc, logic ed);
			answer_t ans;
			if (waiting.size() == 0) begin
				$error("result word with nothing expected: max_components=%0d edge_dropped=%0d",
					mc, ed);
				fails++;
				return;
			end
			ans = waiting.pop_front();
			checked++;
			if (mc !== ans.max_components) begin
				$error("max_components: expected %0d, got %0d", ans.max_components, mc);
				fails++;
			end
			if (ed !== ans.edge_dropped) begin
				$error("edge_dropped: expected %0d, got %0d", ans.edge_dropped, ed);
				fails++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 200000; // cycles without any accepted word
	localparam int CLEAR_WAIT  = 1100;   // covers the clearing pass
	localparam int EDGE_WAIT   = 20;     // covers the last edge write

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic             kind;
	logic [VTX_W-1:0] endpoint_a;
	logic [VTX_W-1:0] endpoint_b;
	logic             out_valid;
	logic             out_stall;
	logic [CNT_W-1:0] max_components;
	logic             edge_dropped;

	answer_board board;
	bit          calm;       // no idling on either side while set
	int          words_sent;
	int          graphs_run;
	int          quiet_cycles;

	max_components_after_vertex_removal DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.endpoint_a     (endpoint_a),
		.endpoint_b     (endpoint_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.max_components (max_components),
		.edge_dropped   (edge_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall about a third of the time unless the bench is calm
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
		end
	end

	// Sample at the falling edge, where every handshake signal is settled;
	// a word seen here is taken by the next rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note_word(kind, endpoint_a, endpoint_b);
				words_sent <= words_sent + 1;
			end
			if (out_valid && !out_stall) begin
				board.check_word(max_components, edge_dropped);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Offer one word and hold it until taken; called and returns at a rising edge
	task automatic offer(input logic k, input logic [VTX_W-1:0] a,
			input logic [VTX_W-1:0] b);
		int gap;
		gap = (!calm && $urandom_range(99) < 34) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		endpoint_a <= a;
		endpoint_b <= b;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
	endtask

	task automatic add_edge(input int a, input int b);
		offer(1'b0, VTX_W'(a), VTX_W'(b));
	endtask

	// Finish the graph, drop valid, then wait for its answer and the clearing pass
	task automatic finish_graph();
		offer(1'b1, VTX_W'($urandom), VTX_W'($urandom));
		in_valid <= 1'b0;
		while (board.waiting.size() != 0)
			@(posedge clk);
		repeat (CLEAR_WAIT) @(posedge clk);
		graphs_run++;
	endtask

	// Write the vertex count; the block must be idle
	task automatic set_vertices(input int v);
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		board.set_count(CNT_W'(v));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Lower the count after loading: let the last edge settle, then write
	task automatic shrink_to(input int v);
		in_valid <= 1'b0;
		repeat (EDGE_WAIT) @(posedge clk);
		set_vertices(v);
	endtask

	// Random graph: mostly in-range edges, tree-like half the time, some noise
	task automatic random_graph(input int nv, input int edges);
		int a, b;
		for (int i = 0; i < edges; i++) begin
			if (nv == 0 || $urandom_range(99) < 10) begin
				a = $urandom_range(1023);
				b = $urandom_range(1023);
			end else if ($urandom_range(1) && nv > 1) begin
				a = $urandom_range(nv - 1, 1);
				b = $urandom_range(a - 1);
			end else begin
				a = $urandom_range(nv - 1);
				b = $urandom_range(nv - 1);
			end
			if ($urandom_range(1))
				add_edge(a, b);
			else
				add_edge(b, a);
		end
	endtask

	initial begin
		int nv, ne, pick;
		board        = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		kind         = 1'b0;
		endpoint_a   = '0;
		endpoint_b   = '0;
		calm         = 1'b0;
		words_sent   = 0;
		graphs_run   = 0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing pass that follows reset
		repeat (CLEAR_WAIT) @(posedge clk);

		// Directed: empty graph, then a single isolated vertex
		set_vertices(0);
		add_edge(0, 0);
		finish_graph();
		set_vertices(1);
		finish_graph();

		// Path with a self loop, a repeated edge and out-of-range endpoints
		set_vertices(5);
		add_edge(0, 1);
		add_edge(1, 2);
		add_edge(2, 3);
		add_edge(2, 2);
		add_edge(1, 2);
		add_edge(1023, 0);
		add_edge(4, 1023);
		finish_graph();

		// Count above the vertex limit behaves as the limit
		set_vertices(2047);
		add_edge(1023, 0);
		add_edge(512, 511);
		add_edge(0, 511);
		finish_graph();

		// Star, then lower the count so edges to the centre are skipped
		set_vertices(8);
		add_edge(7, 0);
		add_edge(7, 1);
		add_edge(7, 2);
		add_edge(0, 1);
		add_edge(3, 4);
		shrink_to(6);
		finish_graph();

		// Random graphs with a calm stretch in the middle
		while (words_sent < 500) begin
			calm = (graphs_run >= 14 && graphs_run < 20);
			pick = $urandom_range(99);
			if (pick < 6)
				nv = 1024;
			else if (pick < 10)
				nv = $urandom_range(2047);
			else
				nv = $urandom_range(24, 2);
			ne = $urandom_range(30);
			set_vertices(nv);
			random_graph(nv, ne);
			if ($urandom_range(99) < 20 && nv > 1)
				shrink_to($urandom_range(nv - 1));
			finish_graph();
		end

		calm = 1'b0;
		in_valid <= 1'b0;
		repeat (CLEAR_WAIT) @(posedge clk);

		$display("covered %0d graphs from %0d input words, %0d answers checked",
			graphs_run, words_sent, board.checked);
		if (board.fails == 0 && board.waiting.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
